/* design/pproj_pkg.sv */
// Shared constants for the pose projection unit.
`default_nettype none

package pproj_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;

    localparam logic [16:0] NEAR_EPS_RESET = 17'd66;

    // round(2^(64-FRAC_BITS) / (2 pi)): heading to 2^32 phase units per turn
    localparam logic [45:0] TURN_K  = 46'd44798133900177;
    localparam int          K_SPLIT = 23;

    localparam int                 CORDIC_N    = 28;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [29:0] ATAN_TURNS [0:27] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5
    };

    // floor(2^(28+FRAC_BITS) / 100000)
    localparam logic signed [65:0] DET_MIN = 66'sd175921860;

    localparam logic signed [49:0] I32_MAX_W = 50'sd2147483647;
    localparam logic signed [49:0] I32_MIN_W = -50'sd2147483648;

endpackage

`default_nettype wire

/* design/pose_projection_on_polyline_unit.sv */
// Top level: trajectory store and query sequencer for pose projection.
`default_nettype none

// Stores up to MAX_POINTS trajectory poses in one RAM (x, y, heading per word)
// and projects a query pose onto the stored polyline along the pose's lateral
// normal. A load request (s_tuser[0] = 0) writes one point; s_tuser[1] empties
// the list first, and loads past MAX_POINTS are dropped. A query request
// (s_tuser[0] = 1) runs sin/cos on an iterative CORDIC, then walks the
// segments through the single RAM read port (differences, four products,
// determinant, sign normalization, test per segment), then one bit-serial
// divide for the fraction and three interpolations on a shared multiplier.
// With fewer than two points a query skips the search and answers not found.
// One result per query, none per load; m_tuser is the found flag and a
// not-found result carries all-zero data. s_tready is high only while no
// query is in flight, and a finished result waits in the output register
// without blocking the next request.
module pose_projection_on_polyline_unit #(
    parameter int MAX_POINTS = 256
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire [16:0]   cfg_wr_data,   // near_eps
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [95:0]   s_tdata,       // pose_x, pose_y, pose_heading
    input  wire [1:0]    s_tuser,       // req_type, start_new
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [135:0] m_tdata,       // segment_index, segment_fraction,
                                        // proj_x, proj_y, proj_heading
    output logic [0:0]   m_tuser        // found
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 3 * pproj_pkg::COORD_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SINCOS = 4'd1;
    localparam logic [3:0] ST_RDA    = 4'd2;
    localparam logic [3:0] ST_DIFF   = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_SUM    = 4'd5;
    localparam logic [3:0] ST_NORM   = 4'd6;
    localparam logic [3:0] ST_TEST   = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_LSUB   = 4'd9;
    localparam logic [3:0] ST_LMUL   = 4'd10;
    localparam logic [3:0] ST_LADD   = 4'd11;
    localparam logic [3:0] ST_OUT    = 4'd12;

    localparam logic [1:0] LANE_X = 2'd0;
    localparam logic [1:0] LANE_Y = 2'd1;
    localparam logic [1:0] LANE_H = 2'd2;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          passed_reg, passed_next;
    logic          found_reg, found_next;
    logic [1:0]    lane_reg, lane_next;
    logic          m_tvalid_reg;
    logic [16:0]   near_eps_reg;

    // datapath
    logic signed [31:0]  qx_reg, qy_reg;
    logic signed [31:0]  nx_reg, ny_reg;
    logic signed [31:0]  ax_reg, ay_reg, ah_reg;
    logic signed [31:0]  bx_reg, by_reg, bh_reg;
    logic signed [32:0]  dx_reg, dy_reg, ex_reg, ey_reg;
    logic                near_reg;
    logic signed [64:0]  p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [65:0]  det_reg, num_reg;
    logic signed [31:0]  mu_reg;
    logic signed [31:0]  la_reg;
    logic [32:0]         dl_reg;
    logic                dneg_reg;
    logic [64:0]         prod_reg;
    logic signed [31:0]  rx_reg, ry_reg, rh_reg;
    logic [135:0]        m_tdata_reg;
    logic                m_tuser_reg;

    logic          s_acc;
    logic          in_query;
    logic [CW-1:0] cnt_base;
    logic          ld_we;
    logic [PW-1:0] rdata;
    logic signed [31:0] mem_x, mem_y, mem_h;

    logic          cord_start, cord_done;
    logic signed [31:0] cord_sin, cord_cos;

    logic          last_seg, big_det, seg_ok, take;
    logic [65:0]   num_abs;
    logic          div_start, div_done;
    logic signed [31:0] div_quo;

    logic [32:0]   adx, ady;
    logic signed [31:0] lane_a, lane_b;
    logic signed [32:0] lane_d;
    logic [31:0]   mu_mag;
    logic [64:0]   rnd;
    logic signed [49:0] lsum;
    logic signed [31:0] lres;
    logic [AW+7:0] idx_wide;
    logic          out_free;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_query = s_tuser[0];
    assign cnt_base = s_tuser[1] ? '0 : count_reg;
    assign ld_we    = s_acc && !in_query && (cnt_base < CW'(MAX_POINTS));

    pproj_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_pt_ram (
        .clk   (aclk),
        .we    (ld_we),
        .waddr (cnt_base[AW-1:0]),
        .wdata (s_tdata),
        .raddr (rd_addr_next),
        .rdata (rdata)
    );

    assign mem_x = rdata[31:0];
    assign mem_y = rdata[63:32];
    assign mem_h = rdata[95:64];

    assign cord_start = s_acc && in_query && (count_reg >= CW'(2));

    pproj_cordic u_cordic (
        .clk     (aclk),
        .rst_n   (aresetn),
        .start   (cord_start),
        .heading (s_tdata[95:64]),
        .done    (cord_done),
        .sin_q   (cord_sin),
        .cos_q   (cord_cos)
    );

    // segment test on the sign-normalized determinant
    assign last_seg = (CW'(idx_reg) + CW'(2)) == count_reg;
    assign big_det  = det_reg > pproj_pkg::DET_MIN;
    assign seg_ok   = (!num_reg[65] && (num_reg < det_reg))
                   || (!passed_reg && (num_reg <= det_reg))
                   || (last_seg && !num_reg[65]);
    assign take      = !near_reg && big_det && seg_ok;
    assign div_start = (state_reg == ST_TEST) && take;
    assign num_abs   = num_reg[65] ? 66'(-num_reg) : 66'(num_reg);

    pproj_div u_div (
        .clk     (aclk),
        .rst_n   (aresetn),
        .start   (div_start),
        .neg     (num_reg[65]),
        .num_mag (num_abs[63:0]),
        .den     (det_reg[63:0]),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign adx = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ady = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);

    always_comb begin
        case (lane_reg)
            LANE_X: begin
                lane_a = ax_reg;
                lane_b = bx_reg;
            end
            LANE_Y: begin
                lane_a = ay_reg;
                lane_b = by_reg;
            end
            default: begin
                lane_a = ah_reg;
                lane_b = bh_reg;
            end
        endcase
    end

    // interpolation: a + mu*(b-a), product rounded half away from zero
    assign lane_d = {lane_b[31], lane_b} - {lane_a[31], lane_a};
    assign mu_mag = mu_reg[31] ? 32'(-mu_reg) : 32'(mu_reg);
    assign rnd    = prod_reg + 65'(1 << (pproj_pkg::FRAC_BITS - 1));
    assign lsum   = dneg_reg
                  ? ({{18{la_reg[31]}}, la_reg} - $signed({1'b0, rnd[64:16]}))
                  : ({{18{la_reg[31]}}, la_reg} + $signed({1'b0, rnd[64:16]}));
    assign lres   = (lsum > pproj_pkg::I32_MAX_W) ? 32'sh7FFF_FFFF
                  : (lsum < pproj_pkg::I32_MIN_W) ? 32'sh8000_0000
                  : lsum[31:0];

    assign idx_wide = {8'b0, idx_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rd_addr_next = rd_addr_reg;
        passed_next  = passed_reg;
        found_next   = found_reg;
        lane_next    = lane_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (!in_query) begin
                        count_next = ld_we ? (cnt_base + CW'(1)) : cnt_base;
                    end else if (count_reg < CW'(2)) begin
                        found_next = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SINCOS;
                    end
                end
            end
            ST_SINCOS: begin
                if (cord_done) begin
                    rd_addr_next = '0;
                    state_next   = ST_RDA;
                end
            end
            ST_RDA: begin
                rd_addr_next = AW'(1);
                idx_next     = '0;
                passed_next  = 1'b0;
                state_next   = ST_DIFF;
            end
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_NORM;
            ST_NORM: state_next = ST_TEST;
            ST_TEST: begin
                if (take) begin
                    state_next = ST_DIV;
                end else begin
                    if (!near_reg) begin
                        passed_next = 1'b1;
                    end
                    if (last_seg) begin
                        found_next = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        idx_next     = idx_reg + AW'(1);
                        rd_addr_next = idx_reg + AW'(2);
                        state_next   = ST_DIFF;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    lane_next  = LANE_X;
                    state_next = ST_LSUB;
                end
            end
            ST_LSUB: state_next = ST_LMUL;
            ST_LMUL: state_next = ST_LADD;
            ST_LADD: begin
                if (lane_reg == LANE_H) begin
                    found_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = ST_LSUB;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_addr_reg  <= '0;
            passed_reg   <= 1'b0;
            found_reg    <= 1'b0;
            lane_reg     <= LANE_X;
            m_tvalid_reg <= 1'b0;
            near_eps_reg <= pproj_pkg::NEAR_EPS_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_addr_reg <= rd_addr_next;
            passed_reg  <= passed_next;
            found_reg   <= found_next;
            lane_reg    <= lane_next;
            if (cfg_wr_en) begin
                near_eps_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    qx_reg <= s_tdata[31:0];
                    qy_reg <= s_tdata[63:32];
                end
            end
            ST_SINCOS: begin
                if (cord_done) begin
                    nx_reg <= cord_sin;
                    ny_reg <= -cord_cos;
                end
            end
            ST_RDA: begin
                ax_reg <= mem_x;
                ay_reg <= mem_y;
                ah_reg <= mem_h;
            end
            ST_DIFF: begin
                bx_reg <= mem_x;
                by_reg <= mem_y;
                bh_reg <= mem_h;
                dx_reg <= {ax_reg[31], ax_reg} - {mem_x[31], mem_x};
                dy_reg <= {ay_reg[31], ay_reg} - {mem_y[31], mem_y};
                ex_reg <= {ax_reg[31], ax_reg} - {qx_reg[31], qx_reg};
                ey_reg <= {ay_reg[31], ay_reg} - {qy_reg[31], qy_reg};
            end
            ST_MUL: begin
                p1_reg   <= nx_reg * dy_reg;
                p2_reg   <= dx_reg * ny_reg;
                p3_reg   <= nx_reg * ey_reg;
                p4_reg   <= ny_reg * ex_reg;
                near_reg <= (adx < {16'b0, near_eps_reg}) && (ady < {16'b0, near_eps_reg});
            end
            ST_SUM: begin
                det_reg <= p1_reg - p2_reg;
                num_reg <= p3_reg - p4_reg;
            end
            ST_NORM: begin
                if (det_reg[65]) begin
                    det_reg <= -det_reg;
                    num_reg <= -num_reg;
                end
            end
            ST_TEST: begin
                if (!take) begin
                    ax_reg <= bx_reg;
                    ay_reg <= by_reg;
                    ah_reg <= bh_reg;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mu_reg <= div_quo;
                end
            end
            ST_LSUB: begin
                la_reg   <= lane_a;
                dl_reg   <= lane_d[32] ? 33'(-lane_d) : 33'(lane_d);
                dneg_reg <= lane_d[32] ^ mu_reg[31];
            end
            ST_LMUL: begin
                prod_reg <= mu_mag * dl_reg;
            end
            ST_LADD: begin
                case (lane_reg)
                    LANE_X:  rx_reg <= lres;
                    LANE_Y:  ry_reg <= lres;
                    default: rh_reg <= lres;
                endcase
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tuser_reg <= found_reg;
                    m_tdata_reg <= found_reg
                                 ? {rh_reg, ry_reg, rx_reg, mu_reg, idx_wide[7:0]}
                                 : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

/* design/pproj_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pproj_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire              clk,
    input  wire              we,
    input  wire [AW-1:0]     waddr,
    input  wire [WIDTH-1:0]  wdata,
    input  wire [AW-1:0]     raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/pproj_cordic.sv */
// Iterative sine/cosine of a Q16.16 heading, Q28 results.
`default_nettype none

module pproj_cordic (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire [31:0]         heading,
    output logic               done,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MLO  = 3'd1;
    localparam logic [2:0] ST_MHI  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_ROT  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]         state_reg;
    logic signed [31:0] h_reg;
    logic [63:0]        acc_reg;
    logic               flip_reg;
    logic signed [33:0] z_reg;
    logic signed [32:0] x_reg;
    logic signed [32:0] y_reg;
    logic [4:0]         it_reg;
    logic               done_reg;

    logic [22:0]        k_op;
    logic signed [55:0] prod;
    logic [63:0]        prod64;
    logic [31:0]        phase;
    logic [31:0]        phase_q;
    logic [31:0]        phase_f;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [33:0] atan_v;
    logic signed [32:0] xf;
    logic signed [32:0] yf;
    logic signed [32:0] xr;
    logic signed [32:0] yr;

    // phase product in two halves of the constant on one multiplier
    assign k_op    = (state_reg == ST_MHI) ? pproj_pkg::TURN_K[45:23]
                                           : pproj_pkg::TURN_K[22:0];
    assign prod    = h_reg * $signed({1'b0, k_op});
    assign prod64  = {{8{prod[55]}}, prod};
    assign phase   = acc_reg[63:32];
    assign phase_q = phase + 32'h4000_0000;
    assign phase_f = phase_q[31] ? (phase + 32'h8000_0000) : phase;

    assign xs     = x_reg >>> it_reg;
    assign ys     = y_reg >>> it_reg;
    assign atan_v = $signed({4'b0, pproj_pkg::ATAN_TURNS[it_reg]});

    assign xf = flip_reg ? -x_reg : x_reg;
    assign yf = flip_reg ? -y_reg : y_reg;
    assign xr = (xf + 33'sd2) >>> 2;
    assign yr = (yf + 33'sd2) >>> 2;

    assign done = done_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        h_reg     <= $signed(heading);
                        state_reg <= ST_MLO;
                    end
                end
                ST_MLO: begin
                    acc_reg   <= prod64;
                    state_reg <= ST_MHI;
                end
                ST_MHI: begin
                    acc_reg   <= acc_reg + (prod64 << pproj_pkg::K_SPLIT);
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    flip_reg  <= phase_q[31];
                    z_reg     <= {{2{phase_f[31]}}, phase_f};
                    x_reg     <= pproj_pkg::CORDIC_GAIN;
                    y_reg     <= '0;
                    it_reg    <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_v;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_v;
                    end
                    if (it_reg == 5'(pproj_pkg::CORDIC_N - 1)) begin
                        state_reg <= ST_FIN;
                    end else begin
                        it_reg <= it_reg + 5'd1;
                    end
                end
                ST_FIN: begin
                    sin_q     <= yr[31:0];
                    cos_q     <= xr[31:0];
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/pproj_div.sv */
// Bit-serial fraction divider: num/den in Q.16, truncated, saturated to 32 bits.
`default_nettype none

module pproj_div (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire                neg,
    input  wire [63:0]         num_mag,
    input  wire [63:0]         den,
    output logic               done,
    output logic signed [31:0] quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] r_reg;
    logic [14:0] sh_reg;
    logic [30:0] q_reg;
    logic [63:0] den_reg;
    logic        neg_reg;

    logic [64:0] rs;
    logic        ge;
    logic [64:0] rd;
    logic [30:0] qn;
    logic        ovf;

    assign rs  = {r_reg, sh_reg[14]};
    assign ge  = rs >= {1'b0, den_reg};
    assign rd  = rs - {1'b0, den_reg};
    assign qn  = {q_reg[29:0], ge};
    // integer part of 2^15 or more cannot be shown in Q16.16
    assign ovf = {15'b0, num_mag} >= {den, 15'b0};

    assign done = done_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (ovf) begin
                    quo      <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    r_reg    <= num_mag >> 15;
                    sh_reg   <= num_mag[14:0];
                    q_reg    <= '0;
                    cnt_reg  <= 5'd30;
                    den_reg  <= den;
                    neg_reg  <= neg;
                end
            end else if (busy_reg) begin
                r_reg  <= ge ? rd[63:0] : rs[63:0];
                sh_reg <= {sh_reg[13:0], 1'b0};
                q_reg  <= qn;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quo      <= neg_reg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* design/pproj_chk.sv */
// Port-level checker for the pose projection unit, bound to the top level.
`default_nettype none

module pproj_chk (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire [1:0]   s_tuser,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [135:0] m_tdata,
    input wire [0:0]   m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 136'd0)
        else $error("not-found result carries data");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("load request produced a result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pose_projection_on_polyline_unit pproj_chk u_pproj_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
